/* rtl/mhtq_pkg.sv */
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared widths, request and result codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int ID_W      = 6;
  localparam int REQ_W     = 3;
  localparam int KIND_W    = 3;
  localparam int TIMEOUT_W = 32;
  localparam int NOW_W     = 48;
  localparam int WAIT_W    = 32;
  localparam int MAX_FIRES = 32;

  localparam int DEF_CAPACITY  = 32;
  localparam int DEF_ID_COUNT  = 64;
  localparam int DEF_TIME_BITS = 48;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADJUST = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    RK_FIRED   = 3'd0,
    RK_WAIT    = 3'd1,
    RK_DONE    = 3'd2,
    RK_NOTPRES = 3'd3,
    RK_FULL    = 3'd4
  } res_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOOKUP,
    OP_ARM_OLD,
    OP_ARM_NEW,
    OP_REMOVE,
    OP_TAKE_LAST,
    OP_CLEAR,
    OP_RD_L,
    OP_RD_R,
    OP_RD_P,
    OP_RD_ROOT,
    OP_DOWN,
    OP_UP,
    OP_WRITE_E
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    logic      emit;
    res_kind_e kind;
    logic      last;
    logic      sel_root;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             id_ok;
    logic             present;
    logic             full;
    logic             c_lt_n;
    logic             moved;
    logic             stop_down;
    logic             i_zero;
    logic             stop_up;
    logic             i_lt_n;
    logic             due;
    logic             out_free;
  } status_t;

endpackage

/* rtl/mhtq_if.sv */
// ----------------------------------------------------------------------------
// mhtq_req_if / mhtq_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface mhtq_req_if;
  logic                            valid;
  logic                            ready;
  logic [mhtq_pkg::REQ_W-1:0]      req_type;
  logic [mhtq_pkg::ID_W-1:0]       timer_id;
  logic [mhtq_pkg::TIMEOUT_W-1:0]  timeout_ms;
  logic [mhtq_pkg::NOW_W-1:0]      now_ms;

  modport source (output valid, req_type, timer_id, timeout_ms, now_ms, input ready);
  modport sink (input valid, req_type, timer_id, timeout_ms, now_ms, output ready);
endinterface

interface mhtq_res_if;
  logic                          valid;
  logic                          ready;
  logic [mhtq_pkg::KIND_W-1:0]   result_kind;
  logic [mhtq_pkg::ID_W-1:0]     fired_id;
  logic [mhtq_pkg::WAIT_W-1:0]   next_wait_ms;
  logic                          last;

  modport source (output valid, result_kind, fired_id, next_wait_ms, last, input ready);
  modport sink (input valid, result_kind, fired_id, next_wait_ms, last, output ready);
endinterface

/* rtl/min_heap_timer_queue.sv */
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Timer queue kept as a binary min-heap on expiry, with an id-to-slot table.
// ----------------------------------------------------------------------------
// One request at a time. Each request is loaded, looked up and decided; an
// add or adjust that arms an entry, and a cancel that removes one, then sift
// it through the heap levels (two child reads and a compare per level on the
// way down, a parent read, a wait and a compare per level on the way up). A
// tick reads and checks the root, and removes each expired timer with its
// sift, up to MAX_FIRES per tick.
// The heap memory has one read and one write port; that port and the sift
// loop set the pace. Results leave through a registered beat, and the
// sequencer stalls while a beat waits to be taken.
module min_heap_timer_queue #(
  parameter int CAPACITY  = mhtq_pkg::DEF_CAPACITY,
  parameter int ID_COUNT  = mhtq_pkg::DEF_ID_COUNT,
  parameter int TIME_BITS = mhtq_pkg::DEF_TIME_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mhtq_req_if.sink     req_i,
  mhtq_res_if.source   res_o
);

  mhtq_pkg::cmd_t    cmd;
  mhtq_pkg::status_t status;

  mhtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mhtq_datapath #(
    .CAPACITY  (CAPACITY),
    .ID_COUNT  (ID_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .req_type_i     (req_i.req_type),
    .timer_id_i     (req_i.timer_id),
    .timeout_ms_i   (req_i.timeout_ms),
    .now_ms_i       (req_i.now_ms),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .result_kind_o  (res_o.result_kind),
    .fired_id_o     (res_o.fired_id),
    .next_wait_ms_o (res_o.next_wait_ms),
    .last_o         (res_o.last)
  );

endmodule

/* rtl/mhtq_datapath.sv */
// ----------------------------------------------------------------------------
// mhtq_datapath
// Heap and id-to-slot memories, request registers, sift registers, result beat.
// ----------------------------------------------------------------------------
module mhtq_datapath #(
  parameter int CAPACITY  = mhtq_pkg::DEF_CAPACITY,
  parameter int ID_COUNT  = mhtq_pkg::DEF_ID_COUNT,
  parameter int TIME_BITS = mhtq_pkg::DEF_TIME_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mhtq_pkg::cmd_t                  cmd_i,
  output mhtq_pkg::status_t               status_o,
  input  logic [mhtq_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mhtq_pkg::ID_W-1:0]       timer_id_i,
  input  logic [mhtq_pkg::TIMEOUT_W-1:0]  timeout_ms_i,
  input  logic [mhtq_pkg::NOW_W-1:0]      now_ms_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic [mhtq_pkg::KIND_W-1:0]     result_kind_o,
  output logic [mhtq_pkg::ID_W-1:0]       fired_id_o,
  output logic [mhtq_pkg::WAIT_W-1:0]     next_wait_ms_o,
  output logic                            last_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam int IW = $clog2(ID_COUNT);
  localparam int IDW = mhtq_pkg::ID_W;
  localparam int EW = TIME_BITS + IDW;

  logic [EW-1:0]          heap_mem [CAPACITY];
  logic [AW-1:0]          slot_mem [ID_COUNT];

  logic [mhtq_pkg::REQ_W-1:0]     req_q;
  logic [IDW-1:0]                 id_q;
  logic [mhtq_pkg::TIMEOUT_W-1:0] tmo_q;
  logic [TIME_BITS-1:0]           now_q;
  logic [AW-1:0]                  slot_q;
  logic [CW-1:0]                  count_q;
  logic [ID_COUNT-1:0]            valid_q;
  logic [AW-1:0]                  i_q, start_q;
  logic [EW-1:0]                  e_q, l_q, rd_q;
  logic                           rv_q;
  logic [IDW-1:0]                 k_q;
  logic                           out_valid_q;
  logic [mhtq_pkg::KIND_W-1:0]    kind_q;
  logic [IDW-1:0]                 fid_q;
  logic [mhtq_pkg::WAIT_W-1:0]    wait_q;
  logic                           last_q;

  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] exp_new;
  logic [XW-1:0]        c_x, cr_x, cnt_x;
  logic                 pick_r;
  logic [EW-1:0]        ch;
  logic [AW-1:0]        cidx, p_idx;
  logic [IW-1:0]        idx, rm_idx;
  logic [TIME_BITS-1:0] diff;
  logic [mhtq_pkg::WAIT_W-1:0] wait_v;
  logic [IDW-1:0]       fid_v;
  logic                 out_free;

  logic                 heap_re, heap_we, slot_we;
  logic [AW-1:0]        heap_ra, heap_wa, slot_wd;
  logic [EW-1:0]        heap_wd;
  logic [IW-1:0]        slot_wa;

  assign sum     = {1'b0, now_q} + (TIME_BITS + 1)'(tmo_q);
  assign exp_new = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign c_x     = XW'({i_q, 1'b1});
  assign cr_x    = c_x + XW'(1);
  assign cnt_x   = XW'(count_q);
  assign pick_r  = rv_q && (rd_q[EW-1:IDW] < l_q[EW-1:IDW]);
  assign ch      = pick_r ? rd_q : l_q;
  assign cidx    = pick_r ? AW'(cr_x) : AW'(c_x);
  assign p_idx   = AW'((i_q - AW'(1)) >> 1);
  assign idx     = IW'(id_q);
  assign rm_idx  = cmd_i.sel_root ? IW'(rd_q[IDW-1:0]) : idx;
  assign diff    = rd_q[EW-1:IDW] - now_q;
  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    wait_v = '0;
    if (count_q != '0 && rd_q[EW-1:IDW] > now_q) begin
      if ({1'b0, diff} > (TIME_BITS + 1)'(33'h0_FFFF_FFFF)) begin
        wait_v = '1;
      end else begin
        wait_v = diff[mhtq_pkg::WAIT_W-1:0];
      end
    end
    fid_v = cmd_i.sel_root ? rd_q[IDW-1:0] : id_q;
  end

  always_comb begin
    status_o.req       = req_q;
    status_o.id_ok     = 32'(id_q) < ID_COUNT;
    status_o.present   = status_o.id_ok && valid_q[idx] && (XW'(slot_q) < cnt_x);
    status_o.full      = cnt_x >= XW'(CAPACITY);
    status_o.c_lt_n    = c_x < cnt_x;
    status_o.moved     = i_q != start_q;
    status_o.stop_down = e_q[EW-1:IDW] < ch[EW-1:IDW];
    status_o.i_zero    = i_q == '0;
    status_o.stop_up   = rd_q[EW-1:IDW] < e_q[EW-1:IDW];
    status_o.i_lt_n    = XW'(i_q) < cnt_x;
    status_o.due       = (count_q != '0) && (32'(k_q) != mhtq_pkg::MAX_FIRES) &&
                         (rd_q[EW-1:IDW] <= now_q);
    status_o.out_free  = out_free;
  end

  always_comb begin
    heap_re = 1'b0;
    heap_ra = '0;
    heap_we = 1'b0;
    heap_wa = i_q;
    heap_wd = e_q;
    slot_we = 1'b0;
    slot_wa = IW'(e_q[IDW-1:0]);
    slot_wd = i_q;
    unique case (cmd_i.op)
      mhtq_pkg::OP_REMOVE: begin
        heap_re = 1'b1;
        heap_ra = AW'(count_q - CW'(1));
      end
      mhtq_pkg::OP_RD_L: begin
        heap_re = 1'b1;
        heap_ra = AW'(c_x);
      end
      mhtq_pkg::OP_RD_R: begin
        heap_re = 1'b1;
        heap_ra = AW'(cr_x);
      end
      mhtq_pkg::OP_RD_P: begin
        heap_re = 1'b1;
        heap_ra = p_idx;
      end
      mhtq_pkg::OP_RD_ROOT: begin
        heap_re = 1'b1;
      end
      mhtq_pkg::OP_DOWN: begin
        heap_we = 1'b1;
        heap_wd = ch;
        slot_we = 1'b1;
        slot_wa = IW'(ch[IDW-1:0]);
      end
      mhtq_pkg::OP_UP: begin
        heap_we = 1'b1;
        heap_wd = rd_q;
        slot_we = 1'b1;
        slot_wa = IW'(rd_q[IDW-1:0]);
      end
      mhtq_pkg::OP_WRITE_E: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      rd_q <= heap_mem[heap_ra];
    end
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd_i.op == mhtq_pkg::OP_LOOKUP) begin
      slot_q <= slot_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      valid_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        mhtq_pkg::OP_LOAD: begin
          k_q <= '0;
        end
        mhtq_pkg::OP_ARM_NEW: begin
          count_q      <= count_q + CW'(1);
          valid_q[idx] <= 1'b1;
        end
        mhtq_pkg::OP_REMOVE: begin
          count_q         <= count_q - CW'(1);
          valid_q[rm_idx] <= 1'b0;
          if (cmd_i.sel_root) begin
            k_q <= k_q + IDW'(1);
          end
        end
        mhtq_pkg::OP_CLEAR: begin
          count_q <= '0;
          valid_q <= '0;
        end
        default: begin
        end
      endcase
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      mhtq_pkg::OP_LOAD: begin
        req_q <= req_type_i;
        id_q  <= timer_id_i;
        tmo_q <= timeout_ms_i;
        now_q <= TIME_BITS'(now_ms_i);
      end
      mhtq_pkg::OP_ARM_OLD: begin
        e_q     <= {exp_new, id_q};
        i_q     <= slot_q;
        start_q <= slot_q;
      end
      mhtq_pkg::OP_ARM_NEW: begin
        e_q     <= {exp_new, id_q};
        i_q     <= AW'(count_q);
        start_q <= AW'(count_q);
      end
      mhtq_pkg::OP_REMOVE: begin
        i_q     <= cmd_i.sel_root ? '0 : slot_q;
        start_q <= cmd_i.sel_root ? '0 : slot_q;
      end
      mhtq_pkg::OP_TAKE_LAST: begin
        e_q <= rd_q;
      end
      mhtq_pkg::OP_RD_R: begin
        l_q  <= rd_q;
        rv_q <= cr_x < cnt_x;
      end
      mhtq_pkg::OP_DOWN: begin
        i_q <= cidx;
      end
      mhtq_pkg::OP_UP: begin
        i_q <= p_idx;
      end
      default: begin
      end
    endcase
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      fid_q  <= (cmd_i.kind == mhtq_pkg::RK_FIRED) ? fid_v : '0;
      wait_q <= (cmd_i.kind == mhtq_pkg::RK_WAIT) ? wait_v : '0;
      last_q <= cmd_i.last;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign fired_id_o     = fid_q;
  assign next_wait_ms_o = wait_q;
  assign last_o         = last_q;

endmodule

/* rtl/mhtq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhtq_ctrl
// Request sequencer: lookup, decide, sift down then up, tick fire loop.
// ----------------------------------------------------------------------------
module mhtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  mhtq_pkg::status_t status_i,
  output mhtq_pkg::cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_LOOK = 13'h0002,
    S_DEC  = 13'h0004,
    S_RML  = 13'h0008,
    S_SDL  = 13'h0010,
    S_SDR  = 13'h0020,
    S_SDC  = 13'h0040,
    S_SUP  = 13'h0080,
    S_SUC  = 13'h0100,
    S_WRE  = 13'h0200,
    S_TRD  = 13'h0400,
    S_TCK  = 13'h0800,
    S_SPR  = 13'h1000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = mhtq_pkg::OP_NONE;
    cmd_o.emit     = 1'b0;
    cmd_o.kind     = mhtq_pkg::RK_DONE;
    cmd_o.last     = 1'b1;
    cmd_o.sel_root = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = mhtq_pkg::OP_LOAD;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.op = mhtq_pkg::OP_LOOKUP;
        state_d  = S_DEC;
      end
      S_DEC: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
          priority if (status_i.req == mhtq_pkg::REQ_ADD) begin
            priority if (!status_i.id_ok) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = mhtq_pkg::RK_NOTPRES;
            end else if (status_i.present) begin
              cmd_o.op = mhtq_pkg::OP_ARM_OLD;
              state_d  = S_SDL;
            end else if (status_i.full) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = mhtq_pkg::RK_FULL;
            end else begin
              cmd_o.op = mhtq_pkg::OP_ARM_NEW;
              state_d  = S_SDL;
            end
          end else if (status_i.req == mhtq_pkg::REQ_ADJUST) begin
            if (status_i.present) begin
              cmd_o.op = mhtq_pkg::OP_ARM_OLD;
              state_d  = S_SDL;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = mhtq_pkg::RK_NOTPRES;
            end
          end else if (status_i.req == mhtq_pkg::REQ_CANCEL) begin
            cmd_o.emit = 1'b1;
            if (status_i.present) begin
              cmd_o.kind = mhtq_pkg::RK_FIRED;
              cmd_o.op   = mhtq_pkg::OP_REMOVE;
              state_d    = S_RML;
            end else begin
              cmd_o.kind = mhtq_pkg::RK_NOTPRES;
            end
          end else if (status_i.req == mhtq_pkg::REQ_TICK) begin
            state_d = S_TRD;
          end else if (status_i.req == mhtq_pkg::REQ_CLEAR) begin
            cmd_o.op   = mhtq_pkg::OP_CLEAR;
            cmd_o.emit = 1'b1;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      S_RML: begin
        if (status_i.i_lt_n) begin
          cmd_o.op = mhtq_pkg::OP_TAKE_LAST;
          state_d  = S_SDL;
        end else begin
          state_d = (status_i.req == mhtq_pkg::REQ_CANCEL) ? S_IDLE : S_TRD;
        end
      end
      S_SDL: begin
        if (status_i.c_lt_n) begin
          cmd_o.op = mhtq_pkg::OP_RD_L;
          state_d  = S_SDR;
        end else begin
          state_d = status_i.moved ? S_WRE : S_SUP;
        end
      end
      S_SDR: begin
        cmd_o.op = mhtq_pkg::OP_RD_R;
        state_d  = S_SDC;
      end
      S_SDC: begin
        if (status_i.stop_down) begin
          state_d = status_i.moved ? S_WRE : S_SUP;
        end else begin
          cmd_o.op = mhtq_pkg::OP_DOWN;
          state_d  = S_SDL;
        end
      end
      S_SUP: begin
        if (status_i.i_zero) begin
          state_d = S_WRE;
        end else begin
          cmd_o.op = mhtq_pkg::OP_RD_P;
          state_d  = S_SPR;
        end
      end
      S_SPR: begin
        state_d = S_SUC;
      end
      S_SUC: begin
        if (status_i.stop_up) begin
          state_d = S_WRE;
        end else begin
          cmd_o.op = mhtq_pkg::OP_UP;
          state_d  = S_SUP;
        end
      end
      S_WRE: begin
        priority if (status_i.req == mhtq_pkg::REQ_TICK) begin
          cmd_o.op = mhtq_pkg::OP_WRITE_E;
          state_d  = S_TRD;
        end else if (status_i.req == mhtq_pkg::REQ_CANCEL) begin
          cmd_o.op = mhtq_pkg::OP_WRITE_E;
          state_d  = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op   = mhtq_pkg::OP_WRITE_E;
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_TRD: begin
        cmd_o.op = mhtq_pkg::OP_RD_ROOT;
        state_d  = S_TCK;
      end
      S_TCK: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel_root = 1'b1;
          if (status_i.due) begin
            cmd_o.kind = mhtq_pkg::RK_FIRED;
            cmd_o.last = 1'b0;
            cmd_o.op   = mhtq_pkg::OP_REMOVE;
            state_d    = S_RML;
          end else begin
            cmd_o.kind = mhtq_pkg::RK_WAIT;
            state_d    = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/mhtq_chk.sv */
// ----------------------------------------------------------------------------
// mhtq_chk
// Port-level checks on the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhtq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [mhtq_pkg::KIND_W-1:0]   result_kind_i,
  input logic [mhtq_pkg::ID_W-1:0]     fired_id_i,
  input logic [mhtq_pkg::WAIT_W-1:0]   next_wait_ms_i,
  input logic                          last_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  a_id_only_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && result_kind_i != mhtq_pkg::RK_FIRED |-> fired_id_i == '0)
    else $error("fired id on a non-fire beat");

  a_wait_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && result_kind_i != mhtq_pkg::RK_WAIT |-> next_wait_ms_i == '0)
    else $error("wait value on a non-wait beat");

  a_not_last_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> result_kind_i == mhtq_pkg::RK_FIRED)
    else $error("non-final beat that is not a fire");

endmodule

bind min_heap_timer_queue mhtq_chk u_mhtq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .result_kind_i  (res_o.result_kind),
  .fired_id_i     (res_o.fired_id),
  .next_wait_ms_i (res_o.next_wait_ms),
  .last_i         (res_o.last)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Timer queue check: random and directed requests go into the heap, and a
// scoreboard predicts every result beat from its own heap and id table.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 32;
  localparam int IDS = 64;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [mhtq_pkg::REQ_W-1:0]     req;
    logic [mhtq_pkg::ID_W-1:0]      id;
    logic [mhtq_pkg::TIMEOUT_W-1:0] tmo;
    logic [mhtq_pkg::NOW_W-1:0]     now;
  } request_t;

  typedef struct packed {
    mhtq_pkg::res_kind_e         kind;
    logic [mhtq_pkg::ID_W-1:0]   fid;
    logic [mhtq_pkg::WAIT_W-1:0] wait_ms;
    logic                        last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  mhtq_req_if req_bus ();
  mhtq_res_if res_bus ();

  min_heap_timer_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus.sink),
    .res_o  (res_bus.source)
  );

  request_t  pending_reqs[$];
  beat_t     expected_beats[$];
  logic [47:0] exp_time[CAP];
  logic [5:0]  exp_id[CAP];
  int          heap_n;
  bit          id_live[IDS];
  int          slot_of[IDS];
  int          errors = 0;
  bit          drain_req = 1'b0;
  bit          stim_done = 1'b0;
  logic [47:0] clock_ms = 48'd1000;

  function automatic void swap_slot(int a, int b);
    logic [47:0] t;
    logic [5:0]  d;
    t = exp_time[a]; exp_time[a] = exp_time[b]; exp_time[b] = t;
    d = exp_id[a]; exp_id[a] = exp_id[b]; exp_id[b] = d;
    slot_of[exp_id[a]] = a;
    slot_of[exp_id[b]] = b;
  endfunction

  function automatic bit sink_down(int s, int n);
    int i;
    int c;
    i = s;
    c = 2 * i + 1;
    while (c < n) begin
      if (c + 1 < n && exp_time[c+1] < exp_time[c]) c++;
      if (exp_time[i] < exp_time[c]) break;
      swap_slot(i, c);
      i = c;
      c = 2 * i + 1;
    end
    return i > s;
  endfunction

  function automatic void float_up(int s);
    int i;
    int p;
    i = s;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (exp_time[p] < exp_time[i]) break;
      swap_slot(i, p);
      i = p;
    end
  endfunction

  function automatic void drop_slot(int idx);
    int n;
    n = heap_n - 1;
    if (idx < n) begin
      swap_slot(idx, n);
      if (!sink_down(idx, n)) float_up(idx);
    end
    id_live[exp_id[n]] = 1'b0;
    heap_n = n;
  endfunction

  function automatic logic [47:0] expiry(logic [47:0] now, logic [31:0] tmo);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, tmo};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic void add_beat(mhtq_pkg::res_kind_e k, logic [5:0] f, logic [31:0] w,
                                   logic l);
    beat_t b;
    b.kind = k; b.fid = f; b.wait_ms = w; b.last = l;
    expected_beats = {expected_beats, b};
  endfunction

  function automatic void predict_timer_queue(request_t r);
    int k;
    logic [47:0] d;
    bit held;
    held = id_live[r.id] && slot_of[r.id] < heap_n;
    case (r.req)
      mhtq_pkg::REQ_ADD, mhtq_pkg::REQ_ADJUST: begin
        if (held) begin
          exp_time[slot_of[r.id]] = expiry(r.now, r.tmo);
          if (!sink_down(slot_of[r.id], heap_n)) float_up(slot_of[r.id]);
          add_beat(mhtq_pkg::RK_DONE, '0, '0, 1'b1);
        end else if (r.req == mhtq_pkg::REQ_ADJUST) begin
          add_beat(mhtq_pkg::RK_NOTPRES, '0, '0, 1'b1);
        end else if (heap_n >= CAP) begin
          add_beat(mhtq_pkg::RK_FULL, '0, '0, 1'b1);
        end else begin
          exp_time[heap_n] = expiry(r.now, r.tmo);
          exp_id[heap_n] = r.id;
          id_live[r.id] = 1'b1;
          slot_of[r.id] = heap_n;
          heap_n++;
          float_up(heap_n - 1);
          add_beat(mhtq_pkg::RK_DONE, '0, '0, 1'b1);
        end
      end
      mhtq_pkg::REQ_CANCEL: begin
        if (!held) add_beat(mhtq_pkg::RK_NOTPRES, '0, '0, 1'b1);
        else begin
          add_beat(mhtq_pkg::RK_FIRED, r.id, '0, 1'b1);
          drop_slot(slot_of[r.id]);
        end
      end
      mhtq_pkg::REQ_TICK: begin
        k = 0;
        while (heap_n > 0 && k < mhtq_pkg::MAX_FIRES && exp_time[0] <= r.now) begin
          add_beat(mhtq_pkg::RK_FIRED, exp_id[0], '0, 1'b0);
          k++;
          drop_slot(0);
        end
        d = '0;
        if (heap_n > 0 && exp_time[0] > r.now) d = exp_time[0] - r.now;
        add_beat(mhtq_pkg::RK_WAIT, '0, (d > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0],
                 1'b1);
      end
      mhtq_pkg::REQ_CLEAR: begin
        heap_n = 0;
        foreach (id_live[i]) id_live[i] = 1'b0;
        add_beat(mhtq_pkg::RK_DONE, '0, '0, 1'b1);
      end
      default: add_beat(mhtq_pkg::RK_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_req(logic [2:0] q, logic [5:0] id, logic [31:0] t,
                                    logic [47:0] n);
    request_t r;
    r.req = q; r.id = id; r.tmo = t; r.now = n;
    pending_reqs = {pending_reqs, r};
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        predict_timer_queue(pending_reqs.pop_front());
        send_gap = gap_len();
      end
      if (req_bus.valid && !req_bus.ready) begin
      end else if (pending_reqs.size() > 0 && send_gap == 0 && !drain_req &&
                   !(pending_reqs[0].req === 3'bx)) begin
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= pending_reqs[0].req;
        req_bus.timer_id   <= pending_reqs[0].id;
        req_bus.timeout_ms <= pending_reqs[0].tmo;
        req_bus.now_ms     <= pending_reqs[0].now;
      end else begin
        req_bus.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // monitor
  int stall = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat kind=%0d id=%0d", res_bus.result_kind, res_bus.fired_id);
          errors++;
        end else begin
          beat_t e;
          e = expected_beats.pop_front();
          if (res_bus.result_kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, res_bus.result_kind); errors++;
          end
          if (res_bus.fired_id !== e.fid) begin
            $error("fired_id exp %0d got %0d", e.fid, res_bus.fired_id); errors++;
          end
          if (res_bus.next_wait_ms !== e.wait_ms) begin
            $error("next_wait_ms exp %0d got %0d", e.wait_ms, res_bus.next_wait_ms);
            errors++;
          end
          if (res_bus.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, res_bus.last); errors++;
          end
        end
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_random_seq();
    int n;
    logic [5:0] id;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      id = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_req(mhtq_pkg::REQ_ADD, id, $urandom_range(0, 300), clock_ms);
        4: queue_req(mhtq_pkg::REQ_ADD, id, $urandom(), clock_ms);
        5: queue_req(mhtq_pkg::REQ_ADJUST, id, $urandom_range(0, 400), clock_ms);
        6: queue_req(mhtq_pkg::REQ_CANCEL, id, $urandom(), clock_ms);
        7: queue_req(3'($urandom_range(5, 7)), id, $urandom(), clock_ms);
        default: begin
          clock_ms = clock_ms + 48'($urandom_range(0, 150));
          queue_req(mhtq_pkg::REQ_TICK, id, $urandom(), clock_ms);
        end
      endcase
    end
  endtask

  initial begin
    heap_n = 0;
    foreach (id_live[i]) begin
      id_live[i] = 1'b0;
      slot_of[i] = 0;
    end
    req_bus.valid = 1'b0;
    req_bus.req_type = '0;
    req_bus.timer_id = '0;
    req_bus.timeout_ms = '0;
    req_bus.now_ms = '0;
    res_bus.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue, extremes, saturation, equal expiries, full heap
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'd0);
    queue_req(mhtq_pkg::REQ_ADJUST, 6'd5, 32'd10, 48'd0);
    queue_req(mhtq_pkg::REQ_CANCEL, 6'd5, 32'd0, 48'd0);
    queue_req(mhtq_pkg::REQ_ADD, 6'd63, 32'hFFFF_FFFF, TMAX);
    queue_req(mhtq_pkg::REQ_ADD, 6'd0, 32'hFFFF_FFFF, 48'hFFFF_0000_0000);
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'd0);
    queue_req(mhtq_pkg::REQ_ADD, 6'd7, 32'd0, 48'hAAAA_5555_AAAA);
    queue_req(mhtq_pkg::REQ_ADD, 6'd7, 32'd5, 48'd100);
    queue_req(mhtq_pkg::REQ_ADD, 6'd8, 32'd5, 48'd100);
    queue_req(mhtq_pkg::REQ_ADJUST, 6'd63, 32'd1, 48'd100);
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'd105);
    queue_req(mhtq_pkg::REQ_CANCEL, 6'd0, 32'd0, 48'd0);
    queue_req(mhtq_pkg::REQ_CLEAR, 6'd0, 32'd0, 48'd0);
    for (int i = 0; i < 33; i++) queue_req(mhtq_pkg::REQ_ADD, 6'(i), 32'd50, 48'd1000);
    queue_req(mhtq_pkg::REQ_ADD, 6'd3, 32'd20, 48'd1000);
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'd1050);
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'd1050);
    queue_req(3'd7, 6'd0, 32'd0, 48'd0);
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, 48'h5555_AAAA_5555);

    while (pending_reqs.size() > 0) @(posedge clk_i);
    drain_req = 1'b1;
    while (expected_beats.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    drain_req = 1'b0;

    clock_ms = 48'd1000;
    queue_req(mhtq_pkg::REQ_CLEAR, 6'd0, 32'd0, 48'd0);
    while (pending_reqs.size() < 280) begin
      if ($urandom_range(0, 9) == 0) queue_req(mhtq_pkg::REQ_CLEAR, 6'd0, 32'd0, 48'd0);
      add_random_seq();
    end
    queue_req(mhtq_pkg::REQ_TICK, 6'd0, 32'd0, TMAX);
    while (pending_reqs.size() > 0) @(posedge clk_i);
    while (expected_beats.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/mhtq_pkg.sv
rtl/mhtq_if.sv
rtl/mhtq_datapath.sv
rtl/mhtq_ctrl.sv
rtl/min_heap_timer_queue.sv
rtl/mhtq_chk.sv
dv/tb_top.sv
